// File: rtl/core/ray_sphere_intersect_core_macros.svh
// Assertion helpers used by the core top-level file.
`ifndef RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/rsi_pkg.sv
package rsi_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DirW    = 18;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned DistW   = 31;
  localparam int unsigned CfgIdxW = 2;

  // q = C - O, b = d.q, radicand and root widths
  localparam int unsigned QW   = CoordW + 1;
  localparam int unsigned BW   = 53;
  localparam int unsigned RadW = 104;
  localparam int unsigned RootW = RadW / 2;

  localparam logic [CfgIdxW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCenterZ = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRadius  = 2'd3;

  localparam logic [RadiusW-1:0] RadiusReset = 31'd65536;
  localparam logic [DistW-1:0]   DistMax     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic                 ok;
    logic signed [BW-1:0] b;
  } rsi_side_t;

endpackage

// File: rtl/core/rsi_dot.sv
module rsi_dot import rsi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic signed [CoordW-1:0]  origin_x_i,
  input  logic signed [CoordW-1:0]  origin_y_i,
  input  logic signed [CoordW-1:0]  origin_z_i,
  input  logic signed [DirW-1:0]    dir_x_i,
  input  logic signed [DirW-1:0]    dir_y_i,
  input  logic signed [DirW-1:0]    dir_z_i,
  input  logic signed [CoordW-1:0]  center_x_i,
  input  logic signed [CoordW-1:0]  center_y_i,
  input  logic signed [CoordW-1:0]  center_z_i,
  input  logic        [RadiusW-1:0] radius_i,
  output logic                      valid_o,
  output logic        [RadW-1:0]    rad_o,
  output rsi_side_t                 side_o
);

  logic [5:0] v_q;

  // stage 1: offset to center
  logic signed [QW-1:0]   q1_q [3];
  logic signed [DirW-1:0] d1_q [3];
  logic [RadiusW-1:0]     r1_q;
  // stage 2: products
  logic signed [50:0]     p2_q [3];
  logic [65:0]            sq2_q [3];
  logic [61:0]            r2_q;
  // stage 3: sums
  logic signed [BW-1:0]   b3_q;
  logic [67:0]            qq3_q;
  logic [61:0]            r3_q;
  // stage 4: partial products of b^2
  logic signed [BW-1:0]   b4_q;
  logic [63:0]            pll4_q;
  logic [51:0]            plh4_q;
  logic [39:0]            phh4_q;
  logic signed [68:0]     rq4_q;
  // stage 5: b^2
  logic signed [BW-1:0]   b5_q;
  logic [RadW-1:0]        b25_q;
  logic signed [68:0]     rq5_q;
  // stage 6: discriminant
  logic [RadW-1:0]        rad6_q;
  rsi_side_t              side6_q;

  logic signed [CoordW-1:0] org [3];
  logic signed [CoordW-1:0] ctr [3];
  logic signed [DirW-1:0]   dir [3];
  logic signed [50:0]       qe [3];
  logic signed [50:0]       de [3];
  logic [QW-1:0]            qa [3];
  logic [51:0]              bm;
  logic signed [105:0]      disc;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign ctr = '{center_x_i, center_y_i, center_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i] = {{(51-QW){q1_q[i][QW-1]}}, q1_q[i]};
      de[i] = {{(51-DirW){d1_q[i][DirW-1]}}, d1_q[i]};
      qa[i] = q1_q[i][QW-1] ? QW'(-q1_q[i]) : QW'(q1_q[i]);
    end
  end

  assign bm   = b3_q[BW-1] ? 52'(-b3_q) : 52'(b3_q);
  assign disc = 106'($signed({2'b00, b25_q})) + 106'($signed({rq5_q, 32'b0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        q1_q[i]  <= QW'(ctr[i]) - QW'(org[i]);
        d1_q[i]  <= dir[i];
        p2_q[i]  <= qe[i] * de[i];
        sq2_q[i] <= 66'(qa[i]) * 66'(qa[i]);
      end
      r1_q   <= radius_i;
      r2_q   <= 62'(r1_q) * 62'(r1_q);
      b3_q   <= BW'(p2_q[0]) + BW'(p2_q[1]) + BW'(p2_q[2]);
      qq3_q  <= 68'(sq2_q[0]) + 68'(sq2_q[1]) + 68'(sq2_q[2]);
      r3_q   <= r2_q;
      b4_q   <= b3_q;
      pll4_q <= 64'(bm[31:0]) * 64'(bm[31:0]);
      plh4_q <= 52'(bm[31:0]) * 52'(bm[51:32]);
      phh4_q <= 40'(bm[51:32]) * 40'(bm[51:32]);
      rq4_q  <= $signed({7'b0, r3_q}) - $signed({1'b0, qq3_q});
      b5_q   <= b4_q;
      b25_q  <= {phh4_q, 64'b0} + RadW'({plh4_q, 33'b0}) + RadW'(pll4_q);
      rq5_q  <= rq4_q;
      side6_q.ok <= !disc[105];
      side6_q.b  <= b5_q;
      rad6_q     <= disc[105] ? '0 : disc[RadW-1:0];
    end
  end

  assign valid_o = v_q[5];
  assign rad_o   = rad6_q;
  assign side_o  = side6_q;

endmodule

// File: rtl/core/rsi_sqrt.sv
module rsi_sqrt import rsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  rsi_side_t        side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output rsi_side_t        side_o
);

  localparam int unsigned RemW = RootW + 2;

  // element 0 is the input; element k+1 is the register after step k
  logic [RadW-1:0]  rad_s  [RootW];
  logic [RemW-1:0]  rem_s  [RootW];
  logic [RootW-1:0] root_s [RootW+1];
  logic             vld_s  [RootW+1];
  rsi_side_t        side_s [RootW+1];

  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign vld_s[0]  = valid_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW+1:0]  cur;
    logic [RemW+1:0]  trial;
    logic             take;
    logic [RemW+1:0]  diff;

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_s[k], rad_s[k][RadW-1 -: 2]};
    assign trial = (RemW+2)'({root_s[k], 2'b01});
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        root_s[k+1] <= {root_s[k][RootW-2:0], take};
        side_s[k+1] <= side_s[k];
      end
    end

    if (k < RootW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_s[k+1] <= take ? diff[RemW-1:0] : cur[RemW-1:0];
          rad_s[k+1] <= rad_s[k] << 2;
        end
      end
    end
  end

  assign valid_o = vld_s[RootW];
  assign root_o  = root_s[RootW];
  assign side_o  = side_s[RootW];

endmodule

// File: rtl/core/ray_sphere_intersect_core.sv
// Channel   Direction  Handshake                    Payload
// ray       in         in_valid_i / in_stall_o      origin_{x,y,z}_i, dir_{x,y,z}_i
// result    out        out_valid_o / out_stall_i    hit_o, distance_o
// config    in         cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// One ray per cycle sustained while no result is stalled; 59 register stages: six
// of dot products and discriminant, 52 of one-bit-per-stage square root, one output
// register. Asynchronous active-low reset clears all valid bits and loads the
// default sphere. A stalled result freezes the whole pipeline in place; in_stall_o
// follows it.
module ray_sphere_intersect_core import rsi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CoordW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  origin_x_i,
  input  logic signed [CoordW-1:0]  origin_y_i,
  input  logic signed [CoordW-1:0]  origin_z_i,
  input  logic signed [DirW-1:0]    dir_x_i,
  input  logic signed [DirW-1:0]    dir_y_i,
  input  logic signed [DirW-1:0]    dir_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [DistW-1:0]          distance_o
);

`include "ray_sphere_intersect_core_macros.svh"

  logic signed [CoordW-1:0] center_x_q, center_y_q, center_z_q;
  logic [RadiusW-1:0]       radius_q;

  logic                     adv;
  logic                     dot_v;
  logic [RadW-1:0]          dot_rad;
  rsi_side_t                dot_side;
  logic                     sq_v;
  logic [RootW-1:0]         sq_root;
  rsi_side_t                sq_side;

  logic signed [BW+1:0]     t0, t1, t_sel;
  logic                     pos0, pos1;
  logic                     hit_d;
  logic [DistW-1:0]         dist_d;
  logic                     out_v_q, hit_q;
  logic [DistW-1:0]         dist_q;

  // Sphere registers: the user must write them only while the pipeline is drained; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= RadiusReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCenterX: center_x_q <= cfg_wdata_i;
        RegCenterY: center_y_q <= cfg_wdata_i;
        RegCenterZ: center_z_q <= cfg_wdata_i;
        RegRadius:  radius_q   <= cfg_wdata_i[RadiusW-1:0];
        default:    ;
      endcase
    end
  end

  // Advance every stage together unless a finished result is held up.
  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  rsi_dot u_dot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .radius_i   (radius_q),
    .valid_o    (dot_v),
    .rad_o      (dot_rad),
    .side_o     (dot_side)
  );

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dot_v),
    .rad_i   (dot_rad),
    .side_i  (dot_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Roots b -/+ sqrt(disc) in Q.32; take the nearer positive one.
  assign t0    = (BW+2)'(sq_side.b) - (BW+2)'($signed({1'b0, sq_root}));
  assign t1    = (BW+2)'(sq_side.b) + (BW+2)'($signed({1'b0, sq_root}));
  assign pos0  = !t0[BW+1] && (t0 != '0);
  assign pos1  = !t1[BW+1] && (t1 != '0);
  assign t_sel = pos0 ? t0 : t1;
  assign hit_d = sq_side.ok && (pos0 || pos1);

  // Drop the low 16 fraction bits and saturate anything past 31 bits; a miss gives zero.
  always_comb begin
    if (!hit_d) begin
      dist_d = '0;
    end else if (t_sel[BW+1:DistW+16] != '0) begin
      dist_d = DistMax;
    end else begin
      dist_d = t_sel[DistW+15:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = hit_q;
  assign distance_o  = dist_q;

  `RSI_ASSERT(a_miss_zero, out_v_q && !hit_q |-> dist_q == '0, "miss with nonzero distance")
  `RSI_ASSERT(a_neg_disc_miss, adv && sq_v && !sq_side.ok |=> !hit_q, "hit on negative disc")
  `RSI_ASSERT(a_freeze, !adv |=> $stable(sq_v) && $stable(sq_root) && $stable(dot_rad), "stage moved")

endmodule

// File: sim/ray_sphere_intersect_core_tb.sv
module ray_sphere_intersect_core_tb;
  import rsi_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] ox;
    logic [CoordW-1:0] oy;
    logic [CoordW-1:0] oz;
    logic [DirW-1:0]   dx;
    logic [DirW-1:0]   dy;
    logic [DirW-1:0]   dz;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] dist_val;
  } hit_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CoordW-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] origin_x_i, origin_y_i, origin_z_i;
  logic signed [DirW-1:0]   dir_x_i, dir_y_i, dir_z_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     hit_o;
  logic [DistW-1:0]         distance_o;

  // Shadow of the sphere registers, as the block should hold them.
  logic [CoordW-1:0]  sph_cx, sph_cy, sph_cz;
  logic [RadiusW-1:0] sph_r;

  hit_t pending_hits[$];
  int   mismatch_cnt;
  int   send_idle_pct;
  int   stall_pct;

  ray_sphere_intersect_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous bound: some 1300 rays at the heaviest stalling used are far below this.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned abs_val(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Exact intersection up to the floor square root, then nearest positive root.
  function automatic hit_t predict_hit(input ray_t ray);
    longint          q[3];
    longint          dir[3];
    longint          b, t0, t1, t;
    longint unsigned mq, mb, root, cand;
    logic [127:0]    qq, pos, neg, disc, sq;
    hit_t            res;
    q[0] = longint'($signed(sph_cx)) - longint'($signed(ray.ox));
    q[1] = longint'($signed(sph_cy)) - longint'($signed(ray.oy));
    q[2] = longint'($signed(sph_cz)) - longint'($signed(ray.oz));
    dir[0] = longint'($signed(ray.dx));
    dir[1] = longint'($signed(ray.dy));
    dir[2] = longint'($signed(ray.dz));
    b = 0;
    qq = '0;
    for (int i = 0; i < 3; i++) begin
      b += dir[i] * q[i];
      mq = abs_val(q[i]);
      qq += 128'(mq) * 128'(mq);
    end
    mb = abs_val(b);
    pos = 128'(mb) * 128'(mb) + ((128'(sph_r) * 128'(sph_r)) << 32);
    neg = qq << 32;
    res = '0;
    if (pos >= neg) begin
      disc = pos - neg;
      root = 0;
      for (int k = 63; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        sq = 128'(cand) * 128'(cand);
        if (disc >= sq) root = cand;
      end
      t0 = b - longint'(root);
      t1 = b + longint'(root);
      t = 0;
      // prefer the near root; fall back to the far one when the origin is inside
      if (t0 > 0) begin
        t = t0;
        res.hit = 1'b1;
      end else if (t1 > 0) begin
        t = t1;
        res.hit = 1'b1;
      end
      if (res.hit) begin
        if ((t >>> 16) > longint'(DistMax)) res.dist_val = DistMax;
        else res.dist_val = DistW'(t >>> 16);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Receiver: stall at random and check every accepted result in order.
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result, hit", hit_o, 0);
      end else begin
        want = pending_hits.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (distance_o !== want.dist_val) report_mismatch("distance", distance_o, want.dist_val);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Send one request; called at a rising edge, returns at the edge that takes it.
  task automatic send_ray(input ray_t ray);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ray.ox;
    origin_y_i <= ray.oy;
    origin_z_i <= ray.oz;
    dir_x_i    <= ray.dx;
    dir_y_i    <= ray.dy;
    dir_z_i    <= ray.dz;
    do @(posedge clk_i); while (in_stall_o);
    pending_hits = {pending_hits, predict_hit(ray)};
  endtask

  // Drop valid and let the pipeline empty, then wait out the tail.
  task automatic drain_all(input int tail);
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegCenterX: sph_cx = val;
      RegCenterY: sph_cy = val;
      RegCenterZ: sph_cz = val;
      RegRadius:  sph_r  = val[RadiusW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [31:0] r);
    drain_all(70);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegRadius, r);
    cfg_we_i <= 1'b0;
  endtask

  function automatic ray_t mk_ray(input int ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox;
    r.oy = oy;
    r.oz = oz;
    r.dx = DirW'(dx);
    r.dy = DirW'(dy);
    r.dz = DirW'(dz);
    return r;
  endfunction

  // Mostly rays aimed near the sphere; the rest are arbitrary bit patterns.
  function automatic ray_t random_ray();
    ray_t r;
    int   span;
    int   axis;
    if ($urandom_range(99) < 20) begin
      r = {$urandom, $urandom, $urandom, 18'($urandom), 18'($urandom), 18'($urandom)};
    end else begin
      span = (sph_r > 31'd1000) ? int'(sph_r) : 1000;
      span = (span > 32'h1000_0000) ? 32'h1000_0000 : span;
      r.ox = sph_cx + $urandom_range(0, 4 * span) - 2 * span;
      r.oy = sph_cy + $urandom_range(0, 4 * span) - 2 * span;
      r.oz = sph_cz + $urandom_range(0, 4 * span) - 2 * span;
      r.dx = DirW'($urandom_range(0, 131072) - 65536);
      r.dy = DirW'($urandom_range(0, 131072) - 65536);
      r.dz = DirW'($urandom_range(0, 131072) - 65536);
      // point one axis straight at the centre now and then
      if ($urandom_range(1)) begin
        axis = $urandom_range(2);
        if (axis == 0) r.dx = ($signed(sph_cx - r.ox) < 0) ? -18'sd65536 : 18'sd65536;
        if (axis == 1) r.dy = ($signed(sph_cy - r.oy) < 0) ? -18'sd65536 : 18'sd65536;
        if (axis == 2) r.dz = ($signed(sph_cz - r.oz) < 0) ? -18'sd65536 : 18'sd65536;
      end
    end
    return r;
  endfunction

  task automatic test_directed();
    // default unit sphere at the origin
    send_ray(mk_ray(0, 0, -5 * 65536, 0, 0, 65536));            // front hit at 4.0
    send_ray(mk_ray(0, 0, 0, 65536, 0, 0));                     // origin inside, far root
    send_ray(mk_ray(0, 0, 5 * 65536, 0, 0, 65536));             // sphere behind the ray
    send_ray(mk_ray(5 * 65536, 5 * 65536, 0, 0, 0, 65536));     // no real root
    send_ray(mk_ray(0, 0, -65537, 0, 0, 32768));                // tiny positive root
    send_ray(mk_ray(0, 0, -65537, 0, 0, 65536));
    send_ray(mk_ray(0, 0, -65536, 0, 0, 65536));                // grazing start on surface
    send_ray(mk_ray(0, 65536, -3 * 65536, 0, 0, 65536));        // tangent
    send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -65536, -65536, -65536));
    send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 65536, 65536, 65536));
    send_ray(mk_ray(0, 0, -3 * 65536, -131072, 131071, 131071)); // direction beyond unit
    send_ray(mk_ray(0, 0, -3 * 65536, 0, 0, -65536));
    send_ray(mk_ray(0, 0, -3 * 65536, 0, 0, 0));                 // zero direction
    send_ray(mk_ray(-1, -1, -1, 1, 1, 1));
    // far sphere: saturate the distance
    set_sphere(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0000_0100);
    send_ray(mk_ray(0, 0, 32'h8000_0000, 0, 0, 65536));
    send_ray(mk_ray(0, 0, 32'h8000_0000, 0, 0, 131071));
    send_ray(mk_ray(0, 0, 32'h8000_0000, 0, 0, -65536));
    // zero and maximum radius, top bit of the write data ignored
    set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, -65536, 0, 0, 65536));
    send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 65536));
    set_sphere(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_ray(mk_ray(0, 0, 0, 65536, 0, 0));
    send_ray(mk_ray(32'h8000_0000, 0, 0, 65536, 0, 0));
    send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65536, 65536, 65536));
  endtask

  // Random rays over many spheres, cycling through the idling profiles.
  task automatic test_random_sweep();
    logic [31:0] cx, cy, cz, r;
    for (int s = 0; s < 10; s++) begin
      case (s % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      cx = $urandom_range(0, 40 * 65536) - 20 * 65536;
      cy = $urandom_range(0, 40 * 65536) - 20 * 65536;
      cz = $urandom_range(0, 40 * 65536) - 20 * 65536;
      r  = $urandom_range(1, 8 * 65536);
      if (s == 8) begin
        cx = 32'h7FFF_0000; cy = 32'h8000_0000; cz = 32'h7FFF_FFFF; r = 32'h7FFF_FFFF;
      end
      if (s == 9) begin
        cx = $urandom; cy = $urandom; cz = $urandom; r = $urandom;
      end
      set_sphere(cx, cy, cz, r);
      for (int n = 0; n < 128; n++) begin
        // hold off once until the pipeline has delivered everything
        if (s == 5 && n == 64) begin
          in_valid_i <= 1'b0;
          while (pending_hits.size() != 0) @(posedge clk_i);
        end
        send_ray(random_ray());
      end
    end
  endtask

  initial begin
    mismatch_cnt  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_r  = RadiusReset;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    origin_x_i  = '0;
    origin_y_i  = '0;
    origin_z_i  = '0;
    dir_x_i     = '0;
    dir_y_i     = '0;
    dir_z_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sweep();
    drain_all(80);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/rsi_dot.sv
rtl/core/rsi_sqrt.sv
rtl/core/ray_sphere_intersect_core.sv
sim/ray_sphere_intersect_core_tb.sv
